FILE: src/frame_bitmap_allocator_assert.svh
// Assertion macros for the frame bitmap allocator.
// Standalone header; the including module supplies clock and reset names.
`ifndef FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define FBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame bitmap allocator: assertion failed");
`define FBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame bitmap allocator: assertion failed");
`else
`define FBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/fba_pkg.sv
// Shared types and constants of the frame bitmap allocator.
// No dependencies.
package fba_pkg;

	localparam int unsigned FRAME_W   = 12;
	localparam int unsigned COUNT_W   = 13;
	localparam int unsigned PADDR_W   = 3;
	localparam int unsigned PDATA_W   = 32;

	localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 13'h1000;
	localparam logic [31:0]        FULL_WORD         = 32'hFFFF_FFFF;

	// register index, taken from paddr[2]
	localparam logic REG_FRAME_COUNT = 1'b0;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_NOP  = 2'd1,
		ST_OOF  = 2'd2
	} status_t;

	typedef struct packed {
		logic               func;
		logic [FRAME_W-1:0] page_frame;
		logic               ring_request;
		logic               write_request;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_out;
		logic               present_bit;
		logic               writable_bit;
		logic               user_bit;
		status_t            status;
	} rsp_t;

endpackage

FILE: src/fba_cfg_regs.sv
// APB-style configuration register (frame_count) of the allocator.
// Depends on fba_pkg.
module fba_cfg_regs import fba_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [COUNT_W-1:0] frame_count
);

	logic [COUNT_W-1:0] frame_count_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_FRAME_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RESET;
		end else if (wr_en) begin
			frame_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_FRAME_COUNT) begin
			prdata = {{(PDATA_W-COUNT_W){1'b0}}, frame_count_q};
		end
	end

	assign frame_count = frame_count_q;

endmodule

FILE: src/fba_bitmap_ram.sv
// Occupancy bitmap store: one write port, one read port, registered read data.
// No dependencies.
module fba_bitmap_ram #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW    = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/fba_first_free.sv
// Lowest clear bit of one bitmap word, and the word with that bit set.
// Depends on fba_pkg.
module fba_first_free import fba_pkg::*; (
	input  logic [31:0] word,
	output logic        found,
	output logic [4:0]  index,
	output logic [31:0] word_set
);

	logic [31:0] low_zero;

	// one-hot of the lowest zero bit
	assign low_zero = ~word & (word + 32'd1);
	assign found    = (word != FULL_WORD);
	assign word_set = word | low_zero;

	always_comb begin
		index = '0;
		for (int b = 0; b < 32; b++) begin
			if (low_zero[b]) begin
				index = index | 5'(b);
			end
		end
	end

endmodule

FILE: src/frame_bitmap_allocator.sv
// Frame bitmap allocator: one occupancy bit per frame, 32-frame words in one RAM.
// A no-op, out-of-range free or zero limit is answered in the cycle after accept; a free
// clears its bit in S_FREE; an allocation scans up to limit words, one RAM read per cycle.
// Throughput: one transaction at a time; busy drops in the done cycle, next start taken there.
// Reset: a clearing pass writes zero to all NUM_FRAMES/32 words (128 by default)
// with busy high; results have no back-pressure and show for one cycle with done.
`include "frame_bitmap_allocator_assert.svh"

module frame_bitmap_allocator import fba_pkg::*; #(
	parameter int unsigned NUM_FRAMES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  req_t               request,
	output logic               done,
	output rsp_t               result,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int unsigned WORD_COUNT = NUM_FRAMES / 32;
	localparam int unsigned AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	// frame_count can name at most 255 whole words
	localparam int unsigned LIM_MAX    = (WORD_COUNT < 255) ? WORD_COUNT : 255;
	localparam logic [7:0]  LIM_MAX_W  = 8'(LIM_MAX);
	localparam logic [AW-1:0] LAST_ADDR = AW'(WORD_COUNT - 1);
	// empty page entry with status done
	localparam rsp_t RSP_EMPTY = '{frame_out: '0, present_bit: 1'b0,
		writable_bit: 1'b0, user_bit: 1'b0, status: ST_DONE};

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FREE
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  clr_q;        // clearing pass address
	logic [7:0]     rd_idx_q;     // word whose data is on rdata during the scan
	logic [4:0]     free_bit_q;   // bit to clear in the free read-modify-write
	logic [AW-1:0]  free_addr_q;
	req_t           req_q;
	logic           done_q;
	rsp_t           result_q;

	logic [COUNT_W-1:0] frame_count;
	logic [7:0]         fc_words;
	logic [7:0]         limit;
	logic               accept;
	logic               free_in_range;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [31:0]        mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [31:0]        mem_rdata;

	logic               word_found;
	logic [4:0]         word_bit;
	logic [31:0]        word_set;
	logic               scan_more;

	fba_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.frame_count (frame_count)
	);

	fba_bitmap_ram #(
		.DEPTH (WORD_COUNT),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fba_first_free u_ff (
		.word     (mem_rdata),
		.found    (word_found),
		.index    (word_bit),
		.word_set (word_set)
	);

	// Search only whole words, clamped to the words the RAM holds.
	assign fc_words = frame_count[COUNT_W-1:5];
	assign limit    = (fc_words > LIM_MAX_W) ? LIM_MAX_W : fc_words;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign free_in_range = (32'(request.page_frame[FRAME_W-1:5]) < WORD_COUNT);
	assign scan_more     = ((9'(rd_idx_q) + 9'd1) < 9'(limit));

	// RAM port steering. Reads of the first word (or the word to free) are
	// issued on the accepting edge so data is ready in the next state.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_raddr = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				if (request.func == FUNC_FREE) begin
					mem_raddr = AW'(request.page_frame[FRAME_W-1:5]);
				end
			end
			S_SCAN: begin
				mem_raddr = AW'(rd_idx_q + 8'd1);
				if (word_found) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(rd_idx_q);
					mem_wdata = word_set;
				end
			end
			S_FREE: begin
				mem_we    = 1'b1;
				mem_waddr = free_addr_q;
				mem_wdata = mem_rdata & ~(32'd1 << free_bit_q);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Control FSM with registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rd_idx_q    <= '0;
			free_bit_q  <= '0;
			free_addr_q <= '0;
			req_q       <= '0;
			done_q      <= 1'b0;
			result_q    <= RSP_EMPTY;
		end else begin
			case (state_q)
				S_CLEAR: begin
					done_q <= 1'b0;
					clr_q  <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						req_q       <= request;
						rd_idx_q    <= '0;
						free_bit_q  <= request.page_frame[4:0];
						free_addr_q <= AW'(request.page_frame[FRAME_W-1:5]);
						if (request.func == FUNC_ALLOC) begin
							if (request.page_frame != '0) begin
								done_q   <= 1'b1;
								result_q <= '{frame_out: request.page_frame,
									present_bit: 1'b0, writable_bit: 1'b0,
									user_bit: 1'b0, status: ST_NOP};
							end else if (limit == 8'd0) begin
								done_q   <= 1'b1;
								result_q <= '{frame_out: '0, present_bit: 1'b0,
									writable_bit: 1'b0, user_bit: 1'b0, status: ST_OOF};
							end else begin
								done_q   <= 1'b0;
								result_q <= RSP_EMPTY;
								state_q  <= S_SCAN;
							end
						end else begin
							if (request.page_frame == '0) begin
								done_q   <= 1'b1;
								result_q <= '{frame_out: '0, present_bit: 1'b0,
									writable_bit: 1'b0, user_bit: 1'b0, status: ST_NOP};
							end else if (!free_in_range) begin
								// past the last word: nothing to clear
								done_q   <= 1'b1;
								result_q <= RSP_EMPTY;
							end else begin
								done_q   <= 1'b0;
								result_q <= RSP_EMPTY;
								state_q  <= S_FREE;
							end
						end
					end else begin
						done_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (word_found) begin
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
						result_q     <= '{frame_out: {rd_idx_q[6:0], word_bit},
							present_bit: 1'b1, writable_bit: req_q.write_request,
							user_bit: ~req_q.ring_request, status: ST_DONE};
					end else if (scan_more) begin
						done_q   <= 1'b0;
						rd_idx_q <= rd_idx_q + 8'd1;
					end else begin
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
						result_q.status <= ST_OOF;
					end
				end
				S_FREE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// A result always coincides with the return to idle.
	`FBA_ASSERT_IMPLY(a_done_idle, clk, arst_n, done, !busy)
	// Freeing frame 0 answers in the next cycle with a no-op.
	`FBA_ASSERT_NEXT(a_free_zero, clk, arst_n, accept && request.func == FUNC_FREE && request.page_frame == '0, done && result.status == ST_NOP)
	// Out of frames hands back nothing.
	`FBA_ASSERT_IMPLY(a_oof_empty, clk, arst_n, done && result.status == ST_OOF, result.frame_out == '0 && !result.present_bit && !result.user_bit)

endmodule

FILE: dv/frame_bitmap_allocator_chk.sv
// Checker for the frame bitmap allocator: watches the command and APB channels,
// predicts each response from its own copy of the bitmap and compares. Uses fba_pkg.
module frame_bitmap_allocator_chk import fba_pkg::*; #(
	parameter int unsigned NUM_FRAMES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  req_t               request,
	input  logic               done,
	input  rsp_t               result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic [PDATA_W-1:0] prdata,
	input  logic               pready,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WORDS = NUM_FRAMES / 32;

	logic [31:0]        occupancy [WORDS];
	logic [COUNT_W-1:0] frame_count_q;
	rsp_t               expected_rsp_q [$];

	function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Applies one transaction to the shadow bitmap and returns its response.
	task automatic serve_request(input req_t r, output rsp_t rsp);
		int unsigned words;
		int unsigned hit;
		bit          found;
		rsp = rsp_t'(0);
		hit = 0;
		if (r.func == FUNC_ALLOC) begin
			if (r.page_frame != '0) begin
				rsp.frame_out = r.page_frame;
				rsp.status    = ST_NOP;
			end else begin
				words = frame_count_q / 32;
				if (words > WORDS)
					words = WORDS;
				found = 1'b0;
				for (int i = 0; i < words && !found; i++) begin
					if (occupancy[i] != FULL_WORD) begin
						for (int j = 0; j < 32 && !found; j++) begin
							if (!occupancy[i][j]) begin
								found = 1'b1;
								hit   = i * 32 + j;
							end
						end
					end
				end
				if (!found) begin
					rsp.status = ST_OOF;
				end else begin
					occupancy[hit / 32][hit % 32] = 1'b1;
					rsp.frame_out    = hit[FRAME_W-1:0];
					rsp.present_bit  = 1'b1;
					rsp.writable_bit = r.write_request;
					rsp.user_bit     = ~r.ring_request;
					rsp.status       = ST_DONE;
				end
			end
		end else begin
			if (r.page_frame == '0) begin
				rsp.status = ST_NOP;
			end else begin
				if (r.page_frame / 32 < WORDS)
					occupancy[r.page_frame / 32][r.page_frame % 32] = 1'b0;
				rsp.status = ST_DONE;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t next_rsp;
		if (!arst_n) begin
			for (int i = 0; i < WORDS; i++)
				occupancy[i] = '0;
			frame_count_q = FRAME_COUNT_RESET;
			expected_rsp_q.delete();
			pending = 0;
			errors  = 0;
		end else begin
			// retire first: the next start may be taken in the done cycle
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					errors++;
					$display("%0t: response with nothing expected: expected none, actual frame %0d status %0d",
						$time, result.frame_out, result.status);
				end else begin
					want = expected_rsp_q.pop_front();
					errors += field_mismatch("frame_out", want.frame_out, result.frame_out);
					errors += field_mismatch("present_bit", want.present_bit, result.present_bit);
					errors += field_mismatch("writable_bit", want.writable_bit, result.writable_bit);
					errors += field_mismatch("user_bit", want.user_bit, result.user_bit);
					errors += field_mismatch("status", want.status, result.status);
				end
			end
			if (start && !busy) begin
				serve_request(request, next_rsp);
				expected_rsp_q.push_back(next_rsp);
			end
			if (psel && penable && pready && paddr[2] == REG_FRAME_COUNT) begin
				if (pwrite)
					frame_count_q = pwdata[COUNT_W-1:0];
				else
					errors += field_mismatch("prdata", PDATA_W'(frame_count_q), prdata);
			end
			pending = expected_rsp_q.size();
		end
	end

endmodule

FILE: dv/frame_bitmap_allocator_tb.sv
// Top of the frame bitmap allocator testbench: clock, reset, APB and command stimulus.
// Depends on fba_pkg, frame_bitmap_allocator and frame_bitmap_allocator_chk.
module frame_bitmap_allocator_tb;
	import fba_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NUM_FRAMES   = 4096;
	// slowest run is ~1720 transactions of a full 128-word scan plus sender gaps,
	// and the limit leaves a wide margin on top
	localparam int unsigned CYCLE_LIMIT  = 1_500_000;
	// longest transaction: scan of every word plus write-back
	localparam int unsigned DRAIN_CYCLES = 140;
	localparam int unsigned PHASE_ITEMS  = 170;
	localparam int unsigned PHASES       = 10;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	req_t               request;
	logic               done;
	rsp_t               result;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int                 errors;
	int                 pending;
	int unsigned        cycles = 0;
	int unsigned        idle_pct;
	// frames handed out by the block and not yet given back by a free transaction
	logic [FRAME_W-1:0] held_frames [$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	frame_bitmap_allocator #(
		.NUM_FRAMES(NUM_FRAMES)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	frame_bitmap_allocator_chk #(
		.NUM_FRAMES(NUM_FRAMES)
	) u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.errors  (errors),
		.pending (pending)
	);

	// watchdog; the simulation ends at the $finish
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Track allocated frames so that most free transactions are well formed.
	// Frame 0 is left out: page_frame 0 means the page holds nothing.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done && result.status == ST_DONE && result.present_bit
				&& result.frame_out != '0)
			held_frames.push_back(result.frame_out);
	end

	// One command transaction. A random gap comes first; start then stays high
	// until the block takes it at an edge with busy low.
	task automatic send(input logic op, input logic [FRAME_W-1:0] frame, input logic ring,
			input logic wr);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		request <= '{func: op, page_frame: frame, ring_request: ring, write_request: wr};
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Drop start and wait until every response is back and the block is idle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
	endtask

	// APB write of frame_count while idle, then a read back for the checker.
	task automatic set_frame_count(input logic [COUNT_W-1:0] value);
		drain();
		paddr   <= {REG_FRAME_COUNT, 2'b00};
		pwdata  <= PDATA_W'(value);
		pwrite  <= 1'b1;
		psel    <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		pwrite  <= 1'b0;
		psel    <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Random phase: mostly allocations of empty pages and frees of held frames,
	// the rest noise (already-held pages, frees of arbitrary or no frame).
	task automatic run_phase(input logic [COUNT_W-1:0] count, input int unsigned pct);
		int unsigned        dice;
		int unsigned        pos;
		logic [FRAME_W-1:0] frame;
		set_frame_count(count);
		idle_pct = pct;
		repeat (PHASE_ITEMS) begin
			dice = $urandom_range(99);
			if (dice < 40 && held_frames.size() != 0) begin
				pos   = $urandom_range(held_frames.size() - 1);
				frame = held_frames[pos];
				held_frames.delete(pos);
				send(FUNC_FREE, frame, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end else if (dice < 85) begin
				send(FUNC_ALLOC, '0, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end else if (dice < 92) begin
				send(FUNC_ALLOC, FRAME_W'($urandom_range(4095, 1)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			end else if (dice < 96) begin
				send(FUNC_FREE, FRAME_W'($urandom_range(4095, 1)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			end else begin
				send(FUNC_FREE, '0, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end
		end
	endtask

	// frame_count per phase: small word counts to reach out-of-frames, zero and
	// sub-word counts, full size, and the 13-bit maximum that gets clamped
	logic [COUNT_W-1:0] phase_count [PHASES] = '{
		13'd32, 13'd64, 13'd4096, 13'd0, 13'd96, 13'h1FFF, 13'd33, 13'd160, 13'd4000, 13'd32
	};
	// sender idle percentage cycles through none, heavy, light
	int unsigned phase_idle [3] = '{0, 84, 26};

	initial begin
		start    <= 1'b0;
		request  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		arst_n   <= 1'b0;
		idle_pct = 0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		// the clearing pass after reset keeps busy high; drain waits it out
		drain();

		// directed part at the reset frame_count
		send(FUNC_FREE, '0, 1'b0, 1'b0);          // nothing to free
		send(FUNC_ALLOC, '0, 1'b0, 1'b0);         // frame zero is handed out
		send(FUNC_ALLOC, '0, 1'b1, 1'b1);
		send(FUNC_ALLOC, '0, 1'b0, 1'b1);
		send(FUNC_ALLOC, '0, 1'b1, 1'b0);
		send(FUNC_ALLOC, 12'hFFF, 1'b1, 1'b1);    // page already holds a frame
		send(FUNC_ALLOC, 12'h001, 1'b0, 1'b0);
		send(FUNC_FREE, 12'h001, 1'b1, 1'b1);     // free, then the same frame comes back
		send(FUNC_ALLOC, '0, 1'b0, 1'b0);
		send(FUNC_FREE, 12'hFFF, 1'b0, 1'b0);     // free of a frame never allocated
		send(FUNC_FREE, 12'hAAA, 1'b1, 1'b0);
		send(FUNC_ALLOC, 12'h555, 1'b0, 1'b1);
		set_frame_count(13'd0);                   // no words searched: out of frames
		send(FUNC_ALLOC, '0, 1'b0, 1'b0);
		send(FUNC_FREE, 12'h002, 1'b0, 1'b0);
		set_frame_count(13'd31);                  // less than one whole word
		send(FUNC_ALLOC, '0, 1'b1, 1'b1);
		set_frame_count(13'h1FFF);                // beyond NUM_FRAMES, clamped
		send(FUNC_ALLOC, '0, 1'b1, 1'b1);
		set_frame_count(13'd32);
		send(FUNC_ALLOC, '0, 1'b0, 1'b1);
		set_frame_count(FRAME_COUNT_RESET);
		send(FUNC_ALLOC, '0, 1'b1, 1'b0);

		for (int p = 0; p < PHASES; p++)
			run_phase(phase_count[p], phase_idle[p % 3]);

		drain();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/fba_pkg.sv
src/fba_cfg_regs.sv
src/fba_bitmap_ram.sv
src/fba_first_free.sv
src/frame_bitmap_allocator.sv
dv/frame_bitmap_allocator_chk.sv
dv/frame_bitmap_allocator_tb.sv
